### design/hgic_pkg.sv
// Package for the halo ghost index calculator: size limits, field widths,
// face and status codes, register indexes and the inter-stage structs.
// No dependencies.
package hgic_pkg;

   localparam int MAX_X = 1024;
   localparam int MAX_Y = 1024;
   localparam int MAX_Z = 256;

   localparam int SIZE_XW    = 11;
   localparam int SIZE_YW    = 11;
   localparam int SIZE_ZW    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int CELL_XW    = 12;
   localparam int CELL_YW    = 12;
   localparam int CELL_ZW    = 10;
   localparam int ADDR_W     = 29;
   localparam int STATUS_W   = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   // Face codes
   localparam logic [2:0] FACE_XP = 3'd0;
   localparam logic [2:0] FACE_XN = 3'd1;
   localparam logic [2:0] FACE_YP = 3'd2;
   localparam logic [2:0] FACE_YN = 3'd3;
   localparam logic [2:0] FACE_ZP = 3'd4;
   localparam logic [2:0] FACE_ZN = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIR   = 2'd2;

   typedef struct packed {
      logic [SIZE_XW-1:0] nx;
      logic [SIZE_YW-1:0] ny;
      logic [SIZE_ZW-1:0] nz;
   } sizes_type;

   // Checked request with first-level products
   typedef struct packed {
      logic                valid;
      logic                ground;
      logic [2:0]          face;
      logic [STATUS_W-1:0] status;
      logic [9:0]          x;
      logic [9:0]          y;
      logic [7:0]          z;
      sizes_type           sizes;
      logic [20:0]         n2;
      logic [19:0]         t;
   } front_type;

endpackage

### design/hgic_cfg.sv
// Size registers of the halo ghost index calculator, with clamping of each
// size to its legal range. Depends on hgic_pkg.
module hgic_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [hgic_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hgic_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hgic_pkg::sizes_type            sizes
);
   import hgic_pkg::*;

   logic [SIZE_XW-1:0] size_x_ff;
   logic [SIZE_YW-1:0] size_y_ff;
   logic [SIZE_ZW-1:0] size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_XW'(1);
         size_y_ff <= SIZE_YW'(1);
         size_z_ff <= SIZE_ZW'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata[SIZE_XW-1:0];
            CSR_SIZE_Y: size_y_ff <= csr_wdata[SIZE_YW-1:0];
            CSR_SIZE_Z: size_z_ff <= csr_wdata[SIZE_ZW-1:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, anything past the maximum reads as the maximum
   always_comb begin
      if (size_x_ff == '0)
         sizes.nx = SIZE_XW'(1);
      else if (size_x_ff > SIZE_XW'(MAX_X))
         sizes.nx = SIZE_XW'(MAX_X);
      else
         sizes.nx = size_x_ff;

      if (size_y_ff == '0)
         sizes.ny = SIZE_YW'(1);
      else if (size_y_ff > SIZE_YW'(MAX_Y))
         sizes.ny = SIZE_YW'(MAX_Y);
      else
         sizes.ny = size_y_ff;

      if (size_z_ff == '0)
         sizes.nz = SIZE_ZW'(1);
      else if (size_z_ff > SIZE_ZW'(MAX_Z))
         sizes.nz = SIZE_ZW'(MAX_Z);
      else
         sizes.nz = size_z_ff;
   end

endmodule

### design/hgic_front.sv
// Front stages: request capture, face and range checks, and the products
// nx*ny and y*nx + x. Depends on hgic_pkg.
module hgic_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                req_cmd,
   input  logic [2:0]                          req_face,
   input  logic signed [hgic_pkg::CELL_XW-1:0] req_cell_x,
   input  logic signed [hgic_pkg::CELL_YW-1:0] req_cell_y,
   input  logic signed [hgic_pkg::CELL_ZW-1:0] req_cell_z,
   input  hgic_pkg::sizes_type                 sizes,
   output hgic_pkg::front_type                 front
);
   import hgic_pkg::*;

   // capture stage
   logic               valid_ff;
   logic               cmd_ff;
   logic [2:0]         face_ff;
   logic [CELL_XW-1:0] x_ff;
   logic [CELL_YW-1:0] y_ff;
   logic [CELL_ZW-1:0] z_ff;
   sizes_type          sizes_ff;

   // check stage
   front_type front_in;
   front_type front_ff;

   logic        xin, yin, zin;
   logic        x_last, y_last, z_last;
   logic        ok, dir_bad;
   logic [21:0] n2_full;
   logic [20:0] t_full;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= req_cmd;
      face_ff  <= req_face;
      x_ff     <= req_cell_x;
      y_ff     <= req_cell_y;
      z_ff     <= req_cell_z;
      sizes_ff <= sizes;
   end

   always_comb begin
      xin    = !x_ff[CELL_XW-1] && (x_ff[SIZE_XW-1:0] < sizes_ff.nx);
      yin    = !y_ff[CELL_YW-1] && (y_ff[SIZE_YW-1:0] < sizes_ff.ny);
      zin    = !cmd_ff || (!z_ff[CELL_ZW-1] && (z_ff[SIZE_ZW-1:0] < sizes_ff.nz));
      x_last = (x_ff == {1'b0, sizes_ff.nx - SIZE_XW'(1)});
      y_last = (y_ff == {1'b0, sizes_ff.ny - SIZE_YW'(1)});
      z_last = (z_ff == {1'b0, sizes_ff.nz - SIZE_ZW'(1)});

      dir_bad = (face_ff > FACE_ZN) || (!cmd_ff && (face_ff > FACE_YN));

      case (face_ff)
         FACE_XP: ok = x_last && yin && zin;
         FACE_XN: ok = (x_ff == '0) && yin && zin;
         FACE_YP: ok = y_last && xin && zin;
         FACE_YN: ok = (y_ff == '0) && xin && zin;
         FACE_ZP: ok = z_last && xin && yin;
         FACE_ZN: ok = (z_ff == '0) && xin && yin;
         default: ok = 1'b0;
      endcase

      // coordinates only matter when the check passes, then they fit 10 bits
      n2_full = 22'(sizes_ff.nx) * 22'(sizes_ff.ny);
      t_full  = 21'(y_ff[9:0]) * 21'(sizes_ff.nx) + 21'(x_ff[9:0]);

      front_in.valid  = valid_ff;
      front_in.ground = cmd_ff;
      front_in.face   = face_ff;
      if (dir_bad)
         front_in.status = ST_DIR;
      else if (ok)
         front_in.status = ST_OK;
      else
         front_in.status = ST_RANGE;
      front_in.x     = x_ff[9:0];
      front_in.y     = y_ff[9:0];
      front_in.z     = z_ff[7:0];
      front_in.sizes = sizes_ff;
      front_in.n2    = n2_full[20:0];
      front_in.t     = t_full[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         front_ff <= '0;
      else
         front_ff <= front_in;
   end

   assign front = front_ff;

endmodule

### design/hgic_back.sv
// Back stages: face offset and multiplier operand select, the layer
// multiply, and the final add into the ghost address. Depends on hgic_pkg.
module hgic_back (
   input  logic                              clock,
   input  logic                              reset,
   input  hgic_pkg::front_type               front,
   output logic                              rsp_valid,
   output logic [hgic_pkg::ADDR_W-1:0]       rsp_ghost_address,
   output logic [hgic_pkg::STATUS_W-1:0]     rsp_status
);
   import hgic_pkg::*;

   // operand stage
   logic                op_valid_ff;
   logic [STATUS_W-1:0] op_status_ff;
   logic [20:0]         op_a_ff, op_a_in;
   logic [8:0]          op_b_ff, op_b_in;
   logic [19:0]         op_add_ff, op_add_in;

   // product stage
   logic                pr_valid_ff;
   logic [STATUS_W-1:0] pr_status_ff;
   logic [29:0]         pr_prod_ff;
   logic [19:0]         pr_add_ff;

   // result stage
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [29:0]         sum;

   logic [12:0] off;
   logic [20:0] surf;
   logic [20:0] m2;

   always_comb begin
      case (front.face)
         FACE_XP: off = 13'({front.sizes.nx, 1'b0}) + 13'(front.y);
         FACE_XN: off = 13'({front.sizes.nx, 1'b0}) + 13'(front.sizes.ny)
                        + 13'(front.y);
         FACE_YP: off = 13'(front.x);
         FACE_YN: off = 13'(front.sizes.nx) + 13'(front.x);
         default: off = '0;
      endcase

      surf = front.n2 + 21'(off);
      // (nx+2)*(ny+2) rebuilt from nx*ny
      m2 = front.n2 + 21'({front.sizes.nx, 1'b0}) + 21'({front.sizes.ny, 1'b0})
           + 21'd4;

      if (front.status != ST_OK) begin
         // drop to zero on any failed request
         op_a_in   = '0;
         op_b_in   = '0;
         op_add_in = '0;
      end else if (!front.ground) begin
         op_a_in   = surf;
         op_b_in   = 9'd1;
         op_add_in = '0;
      end else if (front.face == FACE_ZP || front.face == FACE_ZN) begin
         op_a_in   = m2;
         op_b_in   = (front.face == FACE_ZP) ? front.sizes.nz
                                             : front.sizes.nz + 9'd1;
         op_add_in = front.t;
      end else begin
         op_a_in   = surf;
         op_b_in   = front.sizes.nz;
         op_add_in = 20'(front.z);
      end
   end

   assign sum = pr_prod_ff + 30'(pr_add_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= front.valid;
         pr_valid_ff  <= op_valid_ff;
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_status_ff  <= front.status;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      op_add_ff     <= op_add_in;
      pr_status_ff  <= op_status_ff;
      pr_prod_ff    <= 30'(op_a_ff) * 30'(op_b_ff);
      pr_add_ff     <= op_add_ff;
      rsp_status_ff <= pr_status_ff;
      rsp_addr_ff   <= sum[ADDR_W-1:0];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ghost_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

### design/halo_ghost_index_calculator.sv
// Halo ghost index calculator: one request per cycle while busy is low, through five
// register stages (capture, checks with nx*ny, operand select, layer multiply,
// final add); rsp_valid comes from the final add stage, high for one cycle.
// busy is a registered copy of reset; reset clears valids and sets all sizes
// to 1. Results cannot be held off by the receiver.
// Depends on hgic_pkg, hgic_cfg, hgic_front, hgic_back.
module halo_ghost_index_calculator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [2:0]                          req_face,
   input  logic signed [hgic_pkg::CELL_XW-1:0] req_cell_x,
   input  logic signed [hgic_pkg::CELL_YW-1:0] req_cell_y,
   input  logic signed [hgic_pkg::CELL_ZW-1:0] req_cell_z,
   output logic                                rsp_valid,
   output logic [hgic_pkg::ADDR_W-1:0]         rsp_ghost_address,
   output logic [hgic_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_we,
   input  logic [hgic_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hgic_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hgic_pkg::*;

   logic      busy_ff;
   logic      accept;
   sizes_type sizes;
   front_type front;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   hgic_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sizes     (sizes)
   );

   hgic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_cmd    (req_cmd),
      .req_face   (req_face),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .req_cell_z (req_cell_z),
      .sizes      (sizes),
      .front      (front)
   );

   hgic_back u_back (
      .clock             (clock),
      .reset             (reset),
      .front             (front),
      .rsp_valid         (rsp_valid),
      .rsp_ghost_address (rsp_ghost_address),
      .rsp_status        (rsp_status)
   );

endmodule

### test/ghost_index_checker.sv
`timescale 1ns / 100ps
// Checker for the halo ghost index calculator: tracks the size registers,
// predicts each ghost address and status, and compares results in order.
// Depends on hgic_pkg.
module ghost_index_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_cmd,
   input  logic [2:0]                          req_face,
   input  logic signed [hgic_pkg::CELL_XW-1:0] req_cell_x,
   input  logic signed [hgic_pkg::CELL_YW-1:0] req_cell_y,
   input  logic signed [hgic_pkg::CELL_ZW-1:0] req_cell_z,
   input  logic                                rsp_valid,
   input  logic [hgic_pkg::ADDR_W-1:0]         rsp_ghost_address,
   input  logic [hgic_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_we,
   input  logic [hgic_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hgic_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   import hgic_pkg::*;

   typedef struct {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
   } ghost_result_type;

   logic [SIZE_XW-1:0] size_x_reg;
   logic [SIZE_YW-1:0] size_y_reg;
   logic [SIZE_ZW-1:0] size_z_reg;
   ghost_result_type   expected_ghosts[$];
   ghost_result_type   oldest;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic note_mismatch(input string what, input longint want, input longint got);
      $display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   function automatic ghost_result_type predict_ghost(input logic ground,
                                                      input logic [2:0] face,
                                                      input longint x, input longint y,
                                                      input longint z);
      longint           nx, ny, nz, n2, n3, m2, t, addr;
      logic             ok, xin, yin, zin;
      ghost_result_type r;
      // zero reads as one, anything past the maximum saturates
      nx = (size_x_reg == 0) ? 1 : (size_x_reg > MAX_X) ? MAX_X : size_x_reg;
      ny = (size_y_reg == 0) ? 1 : (size_y_reg > MAX_Y) ? MAX_Y : size_y_reg;
      nz = (size_z_reg == 0) ? 1 : (size_z_reg > MAX_Z) ? MAX_Z : size_z_reg;
      xin  = x >= 0 && x < nx;
      yin  = y >= 0 && y < ny;
      zin  = !ground || (z >= 0 && z < nz);
      ok   = 1'b0;
      addr = 0;
      if (face > FACE_ZN || (!ground && face > FACE_YN)) begin
         r.status = ST_DIR;
      end else if (!ground) begin
         n2 = nx * ny;
         case (face)
            FACE_XP: begin ok = x == nx - 1 && yin; addr = n2 + 2 * nx + y; end
            FACE_XN: begin ok = x == 0 && yin; addr = n2 + 2 * nx + ny + y; end
            FACE_YP: begin ok = y == ny - 1 && xin; addr = n2 + x; end
            default: begin ok = y == 0 && xin; addr = n2 + nx + x; end
         endcase
         r.status = ok ? ST_OK : ST_RANGE;
      end else begin
         n3 = nx * ny * nz;
         m2 = (nx + 2) * (ny + 2);
         t  = y * nx + x;
         case (face)
            FACE_XP: begin
               ok = x == nx - 1 && yin && zin; addr = n3 + 2 * nx * nz + y * nz + z;
            end
            FACE_XN: begin
               ok = x == 0 && yin && zin; addr = n3 + 2 * nx * nz + ny * nz + y * nz + z;
            end
            FACE_YP: begin ok = y == ny - 1 && xin && zin; addr = n3 + x * nz + z; end
            FACE_YN: begin ok = y == 0 && xin && zin; addr = n3 + nx * nz + x * nz + z; end
            FACE_ZP: begin ok = z == nz - 1 && xin && yin; addr = m2 * nz + t; end
            default: begin ok = z == 0 && xin && yin; addr = m2 * (nz + 1) + t; end
         endcase
         r.status = ok ? ST_OK : ST_RANGE;
      end
      r.addr = (r.status == ST_OK && addr >= 0) ? addr[ADDR_W-1:0] : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         size_x_reg = SIZE_XW'(1);
         size_y_reg = SIZE_YW'(1);
         size_z_reg = SIZE_ZW'(1);
         expected_ghosts.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_ghosts.size() == 0) begin
               note_mismatch("unrequested result address", -1, rsp_ghost_address);
            end else begin
               oldest = expected_ghosts.pop_front();
               if (rsp_ghost_address !== oldest.addr)
                  note_mismatch("ghost_address", oldest.addr, rsp_ghost_address);
               if (rsp_status !== oldest.status)
                  note_mismatch("status", oldest.status, rsp_status);
            end
         end
         if (start && !busy)
            expected_ghosts.push_back(predict_ghost(req_cmd, req_face, req_cell_x,
                                                    req_cell_y, req_cell_z));
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_X: size_x_reg = csr_wdata[SIZE_XW-1:0];
               CSR_SIZE_Y: size_y_reg = csr_wdata[SIZE_YW-1:0];
               CSR_SIZE_Z: size_z_reg = csr_wdata[SIZE_ZW-1:0];
               default: ;  // drop writes past the last register
            endcase
         end
      end
      pending_count = expected_ghosts.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Top of the halo ghost index calculator testbench: clock, reset, size
// settings and request stimulus. Depends on hgic_pkg and ghost_index_checker.
module tb_top;
   import hgic_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {ON_FACE, NUDGED, NOISE} aim_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_cmd;
   logic [2:0]                req_face;
   logic signed [CELL_XW-1:0] req_cell_x;
   logic signed [CELL_YW-1:0] req_cell_y;
   logic signed [CELL_ZW-1:0] req_cell_z;
   logic                      rsp_valid;
   logic [ADDR_W-1:0]         rsp_ghost_address;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   int                        mismatch_count;
   int                        pending_count;
   int                        grid_x, grid_y, grid_z;  // sizes in force, for aiming
   int                        guard;

   halo_ghost_index_calculator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_face(req_face), .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y), .req_cell_z(req_cell_z),
      .rsp_valid(rsp_valid), .rsp_ghost_address(rsp_ghost_address),
      .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ghost_index_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_face(req_face), .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y), .req_cell_z(req_cell_z),
      .rsp_valid(rsp_valid), .rsp_ghost_address(rsp_ghost_address),
      .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue(input logic cmd, input logic [2:0] face, input int x, input int y,
                        input int z);
      req_cmd    = cmd;
      req_face   = face;
      req_cell_x = x[CELL_XW-1:0];
      req_cell_y = y[CELL_YW-1:0];
      req_cell_z = z[CELL_ZW-1:0];
      start      = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_case(input logic cmd, input logic [2:0] face, input aim_kind_type kind);
      int x, y, z;
      x = $urandom_range(0, grid_x - 1);
      y = $urandom_range(0, grid_y - 1);
      z = cmd ? $urandom_range(0, grid_z - 1) : $urandom_range(0, 1023);
      case (face)
         FACE_XP: x = grid_x - 1;
         FACE_XN: x = 0;
         FACE_YP: y = grid_y - 1;
         FACE_YN: y = 0;
         FACE_ZP: z = grid_z - 1;
         FACE_ZN: z = 0;
         default: ;
      endcase
      if (kind == NUDGED) begin
         // push one coordinate just off the face or out of the grid
         case ($urandom_range(0, 2))
            0: x = $urandom_range(0, 1) ? x + 1 : x - 1;
            1: y = $urandom_range(0, 1) ? y + 1 : y - 1;
            default: z = $urandom_range(0, 1) ? z + 1 : z - 1;
         endcase
      end else if (kind == NOISE) begin
         x = $urandom_range(0, 4095);
         y = $urandom_range(0, 4095);
         z = $urandom_range(0, 1023);
      end
      issue(cmd, face, x, y, z);
   endtask

   task automatic issue_random(input bit with_gaps);
      logic       cmd;
      logic [2:0] face;
      int         pick;
      if (with_gaps && $urandom_range(0, 5) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      cmd  = 1'($urandom_range(0, 1));
      face = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, 5));
      if (!cmd && face > FACE_YN && $urandom_range(0, 3) != 0)
         face = 3'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      send_case(cmd, face, pick < 70 ? ON_FACE : pick < 85 ? NUDGED : NOISE);
   endtask

   function automatic int grid_size(input int unsigned value, input int unsigned mask,
                                    input int limit);
      int v;
      v = value & mask;
      return (v == 0) ? 1 : (v > limit) ? limit : v;
   endfunction

   task automatic write_size(input logic [CSR_IDX_W-1:0] index, input int unsigned value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_SIZE_X: grid_x = grid_size(value, 'h7FF, MAX_X);
         CSR_SIZE_Y: grid_y = grid_size(value, 'h7FF, MAX_Y);
         CSR_SIZE_Z: grid_z = grid_size(value, 'h1FF, MAX_Z);
         default: ;
      endcase
   endtask

   // Hold requests until every pending result has come back.
   task automatic drain();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned sx, input int unsigned sy, input int unsigned sz,
                            input int count, input bit with_gaps);
      drain();
      write_size(CSR_SIZE_X, sx);
      write_size(CSR_SIZE_Y, sy);
      write_size(CSR_SIZE_Z, sz);
      write_size(CSR_SPARE, $urandom_range(0, 2047));
      repeat (count) issue_random(with_gaps);
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_cmd    = 1'b0;
      req_face   = '0;
      req_cell_x = '0;
      req_cell_y = '0;
      req_cell_z = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      grid_x     = 1;
      grid_y     = 1;
      grid_z     = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset sizes of one cell each way
      repeat (100) issue_random(1'b1);

      drain();
      write_size(CSR_SIZE_X, 5);
      write_size(CSR_SIZE_Y, 4);
      write_size(CSR_SIZE_Z, 3);
      for (int c = 0; c < 2; c++)
         for (int f = 0; f < 8; f++) send_case(c[0], f[2:0], ON_FACE);
      issue(1'b1, FACE_XP, -2048, -2048, -512);
      issue(1'b1, FACE_XN, 2047, 2047, 511);
      issue(1'b0, FACE_YN, 0, 0, -512);
      issue(1'b1, FACE_ZN, 0, 0, -1);
      issue(1'b1, FACE_XP, 4, 3, 3);
      issue(1'b0, FACE_XP, 4, -1, 0);
      issue(1'b1, FACE_ZP, 4, 3, 2);
      repeat (150) issue_random(1'b1);

      run_phase(MAX_X, MAX_Y, MAX_Z, 250, 1'b1);
      // zero and saturating sizes; z keeps only its low nine bits
      run_phase(0, 2047, 2047, 200, 1'b1);
      run_phase(MAX_X + 1, 0, 512, 150, 1'b1);
      repeat (4) begin
         if ($urandom_range(0, 1))
            run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                      120, 1'b1);
         else
            run_phase($urandom_range(1, 1024), $urandom_range(1, 1024),
                      $urandom_range(1, 256), 120, 1'b1);
      end
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 32),
                200, 1'b0);

      start = 1'b0;
      guard = 0;
      while (pending_count != 0 && guard < 2000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
